// File: rtl/env_sensor_frame_decoder_core_defines.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef ENV_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH
`define ENV_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESFD_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESFD_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/esfd_pkg.sv
// Constants and types for the environmental sensor frame decoder.
package esfd_pkg;

    localparam int PosWidth     = 5;
    localparam int PayloadBytes = 14;

    typedef logic [PosWidth-1:0] pos_t;
    typedef logic [7:0]          byte_t;
    typedef logic [15:0]         word_t;

    localparam byte_t HdrFirst  = 8'h3C;
    localparam byte_t HdrSecond = 8'h02;
    localparam byte_t MagMask   = 8'h7F;
    localparam byte_t SignBit   = 8'h80;

    // Frame is 17 bytes: two header bytes, 14 payload bytes, checksum
    localparam pos_t PosHunt         = 5'd0;
    localparam pos_t PosHeader       = 5'd1;
    localparam pos_t PosPayloadFirst = 5'd2;
    localparam pos_t PosPayloadLast  = 5'd15;
    localparam pos_t PosChecksum     = 5'd16;

    localparam logic StatusGood   = 1'b0;
    localparam logic StatusBadSum = 1'b1;

endpackage

// File: rtl/env_sensor_frame_decoder_core.sv
// A result is registered and presented in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; bytes are taken while a result waits, and
// in_stall rises only when a checksum byte meets a full, stalled result register.
// Reset (rst_n, async, active low) clears the frame position, the running sum
// and the result valid; the payload bytes are not cleared and need no sweep.
`include "env_sensor_frame_decoder_core_defines.svh"

module env_sensor_frame_decoder_core
    import esfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [15:0]        co2_ppm,
    output logic [15:0]        formaldehyde,
    output logic [15:0]        tvoc,
    output logic [15:0]        pm25,
    output logic [15:0]        pm10,
    output logic [15:0]        pm25_tenths,
    output logic signed [11:0] temperature_tenths,
    output logic [11:0]        humidity_tenths
);

    pos_t  position_reg, position_next;
    byte_t sum_reg, sum_next;
    byte_t payload_reg [PayloadBytes];

    logic  accept;
    logic  shift_en;
    logic  decode;
    logic  frame_good;

    word_t             pm25_raw;
    logic [10:0]       temp_mag;
    logic signed [11:0] temp_val;
    logic [11:0]       hum_val;

    logic               out_valid_reg;
    logic               status_reg;
    word_t              co2_reg, hcho_reg, tvoc_reg, pm25_reg, pm10_reg, pm25_x10_reg;
    logic signed [11:0] temp_reg;
    logic [11:0]        hum_reg;

    // Only the checksum byte produces a result, so only it waits for the output slot
    assign in_stall = out_valid_reg && out_stall && (position_reg == PosChecksum);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        position_next = position_reg;
        sum_next      = sum_reg;
        shift_en      = 1'b0;
        decode        = 1'b0;
        if (accept)
        begin
            case (position_reg) inside
                PosHunt:
                begin
                    if (data_byte == HdrFirst)
                    begin
                        sum_next      = HdrFirst;
                        position_next = PosHeader;
                    end
                end
                PosHeader:
                begin
                    if (data_byte == HdrSecond)
                    begin
                        sum_next      = sum_reg + data_byte;
                        position_next = PosPayloadFirst;
                    end
                    else if (data_byte == HdrFirst)
                    begin
                        // repeated first header byte is taken as the start of a new frame
                        sum_next      = HdrFirst;
                        position_next = PosHeader;
                    end
                    else
                    begin
                        sum_next      = '0;
                        position_next = PosHunt;
                    end
                end
                [PosPayloadFirst:PosPayloadLast]:
                begin
                    shift_en      = 1'b1;
                    sum_next      = sum_reg + data_byte;
                    position_next = position_reg + pos_t'(1);
                end
                default:
                begin
                    decode        = 1'b1;
                    sum_next      = '0;
                    position_next = PosHunt;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= PosHunt;
            sum_reg      <= '0;
        end
        else
        begin
            position_reg <= position_next;
            sum_reg      <= sum_next;
        end
    end

    // Payload shift line: after 14 bytes, entry 0 holds frame byte 2
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < PayloadBytes - 1; i++)
            begin
                payload_reg[i] <= payload_reg[i+1];
            end
            payload_reg[PayloadBytes-1] <= data_byte;
        end
    end

    // Decode of a completed frame
    always_comb
    begin
        frame_good = (sum_reg == data_byte);
        pm25_raw   = {payload_reg[6], payload_reg[7]};
        temp_mag   = 11'({payload_reg[10][6:0] & MagMask[6:0], 3'b000})
                   + 11'({payload_reg[10][6:0] & MagMask[6:0], 1'b0})
                   + 11'(payload_reg[11]);
        if ((payload_reg[10] & SignBit) != '0)
        begin
            temp_val = -$signed({1'b0, temp_mag});
        end
        else
        begin
            temp_val = $signed({1'b0, temp_mag});
        end
        hum_val    = 12'({payload_reg[12], 3'b000}) + 12'({payload_reg[12], 1'b0})
                   + 12'(payload_reg[13]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (decode)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decode)
        begin
            if (frame_good)
            begin
                status_reg   <= StatusGood;
                co2_reg      <= {payload_reg[0], payload_reg[1]};
                hcho_reg     <= {payload_reg[2], payload_reg[3]};
                tvoc_reg     <= {payload_reg[4], payload_reg[5]};
                pm25_reg     <= pm25_raw;
                pm10_reg     <= {payload_reg[8], payload_reg[9]};
                pm25_x10_reg <= {pm25_raw[12:0], 3'b000} + {pm25_raw[14:0], 1'b0};
                temp_reg     <= temp_val;
                hum_reg      <= hum_val;
            end
            else
            begin
                status_reg   <= StatusBadSum;
                co2_reg      <= '0;
                hcho_reg     <= '0;
                tvoc_reg     <= '0;
                pm25_reg     <= '0;
                pm10_reg     <= '0;
                pm25_x10_reg <= '0;
                temp_reg     <= '0;
                hum_reg      <= '0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign co2_ppm            = co2_reg;
    assign formaldehyde       = hcho_reg;
    assign tvoc               = tvoc_reg;
    assign pm25               = pm25_reg;
    assign pm10               = pm10_reg;
    assign pm25_tenths        = pm25_x10_reg;
    assign temperature_tenths = temp_reg;
    assign humidity_tenths    = hum_reg;

    `ESFD_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, position_reg <= PosChecksum,
        "frame position past checksum byte")
    `ESFD_ASSERT_SAME(a_stall_only_checksum, clk, rst_n, in_stall,
        position_reg == PosChecksum && out_valid_reg,
        "input stalled outside checksum byte")
    `ESFD_ASSERT_NEXT(a_decode_result, clk, rst_n, decode,
        out_valid_reg && position_reg == PosHunt && sum_reg == '0,
        "checksum byte did not give a result and rearm the hunt")
    `ESFD_ASSERT_SAME(a_bad_sum_zero, clk, rst_n, out_valid_reg && status_reg == StatusBadSum,
        co2_reg == '0 && pm25_reg == '0 && temp_reg == '0 && hum_reg == '0,
        "checksum error result carries data")

endmodule
